// ----- rtl/srss_pkg.sv -----
// ----------------------------------------------------------------------------
// srss_pkg
// Shared sizes, codes and types of the sorted row stack search block.
// ----------------------------------------------------------------------------
package srss_pkg;

	// stack geometry
	localparam int MAX_ROWS    = 16;
	localparam int MAX_ROW_LEN = 64;
	localparam int MEM_DEPTH   = MAX_ROWS * MAX_ROW_LEN;

	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int IDX_W  = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
	localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int LEN_W  = $clog2(MAX_ROW_LEN + 1);
	localparam int CNT_W  = $clog2(MAX_ROWS + 1);
	localparam int DATA_W = 32;

	// request codes
	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_SEARCH = 2'd2;

	// result status codes
	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_UNDERFLOW = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_BS_RD,
		S_BS_CMP,
		S_RESP
	} state_t;

	// memory access command from the controller
	typedef struct packed {
		logic                elem_we;
		logic [ADDR_W-1:0]   elem_waddr;
		logic [DATA_W-1:0]   elem_wdata;
		logic [ADDR_W-1:0]   elem_raddr;
		logic                len_we;
		logic [ROW_W-1:0]    len_waddr;
		logic [LEN_W-1:0]    len_wdata;
		logic [ROW_W-1:0]    len_raddr;
	} store_cmd_t;

	// one result word
	typedef struct packed {
		status_t             status;
		logic [IDX_W-1:0]    index;
		logic [ROW_W-1:0]    level;
		logic [CNT_W-1:0]    depth;
	} res_t;

endpackage

// ----- rtl/sorted_row_stack_search.sv -----
// ----------------------------------------------------------------------------
// sorted_row_stack_search
// Bounded stack of ascending rows with load, pop and search requests.
//
//   channel  direction  handshake          fields
//   in       input      in_valid/in_stall  req_type elem_value has_value
//                                          row_last search_key
//   out      output     out_valid/out_stall status found_index found_level
//                                          stack_depth
//
// Load, pop and unknown requests go from accept straight to the result
// register. A search scans row heads downward and then binary-searches one
// row, a probe read and a compare per step, through the one element read port.
// One word is in work at a time; the next one is taken while a result waits
// in the output register. Reset clears the row count and build state; the
// memories are not cleared. A stalled output only holds the sequencer once a
// second result is ready.
// ----------------------------------------------------------------------------
module sorted_row_stack_search (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          req_type,
	input  logic signed [31:0]                  elem_value,
	input  logic                                has_value,
	input  logic                                row_last,
	input  logic signed [31:0]                  search_key,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          status,
	output logic [5:0]                          found_index,
	output logic [3:0]                          found_level,
	output logic [4:0]                          stack_depth
);

	srss_pkg::store_cmd_t               cmd;
	logic [srss_pkg::DATA_W-1:0]        elem_rdata;
	logic [srss_pkg::LEN_W-1:0]         len_rdata;
	srss_pkg::res_t                     res;
	logic                               res_valid;
	logic                               res_ready;
	logic                               out_valid_q;
	srss_pkg::res_t                     out_q;

	srss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.elem_value (elem_value),
		.has_value  (has_value),
		.row_last   (row_last),
		.search_key (search_key),
		.cmd        (cmd),
		.elem_rdata (elem_rdata),
		.len_rdata  (len_rdata),
		.res        (res),
		.res_valid  (res_valid),
		.res_ready  (res_ready)
	);

	srss_store u_store (
		.clk        (clk),
		.cmd        (cmd),
		.elem_rdata (elem_rdata),
		.len_rdata  (len_rdata)
	);

	// output register: load when empty or being drained
	assign res_ready = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = 3'(out_q.status);
	assign found_index = 6'(out_q.index);
	assign found_level = 4'(out_q.level);
	assign stack_depth = 5'(out_q.depth);

endmodule

// ----- rtl/srss_store.sv -----
// ----------------------------------------------------------------------------
// srss_store
// Element memory and row length memory, one write and one registered read
// port each.
// ----------------------------------------------------------------------------
module srss_store (
	input  logic                              clk,
	input  srss_pkg::store_cmd_t              cmd,
	output logic [srss_pkg::DATA_W-1:0]       elem_rdata,
	output logic [srss_pkg::LEN_W-1:0]        len_rdata
);

	logic [srss_pkg::DATA_W-1:0] elem_mem [srss_pkg::MEM_DEPTH];
	logic [srss_pkg::LEN_W-1:0]  len_mem  [srss_pkg::MAX_ROWS];

	// element memory
	always_ff @(posedge clk) begin
		if (cmd.elem_we) begin
			elem_mem[cmd.elem_waddr] <= cmd.elem_wdata;
		end
		elem_rdata <= elem_mem[cmd.elem_raddr];
	end

	// row length memory
	always_ff @(posedge clk) begin
		if (cmd.len_we) begin
			len_mem[cmd.len_waddr] <= cmd.len_wdata;
		end
		len_rdata <= len_mem[cmd.len_raddr];
	end

endmodule

// ----- rtl/srss_ctrl.sv -----
// ----------------------------------------------------------------------------
// srss_ctrl
// Request sequencer: row build and push, pop, and the search that scans
// rows downward and then binary-searches one row through the memories.
// ----------------------------------------------------------------------------
module srss_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           req_type,
	input  logic signed [srss_pkg::DATA_W-1:0]   elem_value,
	input  logic                                 has_value,
	input  logic                                 row_last,
	input  logic signed [srss_pkg::DATA_W-1:0]   search_key,
	output srss_pkg::store_cmd_t                 cmd,
	input  logic [srss_pkg::DATA_W-1:0]          elem_rdata,
	input  logic [srss_pkg::LEN_W-1:0]           len_rdata,
	output srss_pkg::res_t                       res,
	output logic                                 res_valid,
	input  logic                                 res_ready
);

	localparam int LEN_W = srss_pkg::LEN_W;
	localparam int ROW_W = srss_pkg::ROW_W;
	localparam int CNT_W = srss_pkg::CNT_W;
	localparam int IDX_W = srss_pkg::IDX_W;
	localparam int ADDR_W = srss_pkg::ADDR_W;

	// control state
	srss_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] row_cnt_q, row_cnt_d;
	logic [LEN_W-1:0] bld_len_q, bld_len_d;
	logic             bld_ovf_q, bld_ovf_d;
	logic             chk_vld_s1, chk_vld_d;

	// search datapath
	logic signed [srss_pkg::DATA_W-1:0] key_q, key_d;
	logic [CNT_W-1:0]   lvl_q, lvl_d;
	logic [ROW_W-1:0]   chk_lvl_s1, chk_lvl_d;
	logic [ROW_W-1:0]   sel_lvl_q, sel_lvl_d;
	logic signed [LEN_W:0] lo_q, lo_d, hi_q, hi_d;
	logic [IDX_W-1:0]   mid_q, mid_d;
	srss_pkg::res_t     res_q, res_d;

	// address of element idx in row lvl
	function automatic logic [ADDR_W-1:0] elem_addr(input logic [ROW_W-1:0] lvl,
			input logic [IDX_W-1:0] idx);
		elem_addr = ADDR_W'(ADDR_W'(lvl) * ADDR_W'(srss_pkg::MAX_ROW_LEN)) + ADDR_W'(idx);
	endfunction

	// next state and outputs
	always_comb begin
		logic [LEN_W-1:0]   b_len;
		logic               b_ovf;
		logic               qual;
		logic signed [LEN_W:0] mid;
		srss_pkg::status_t  st;

		state_d    = state_q;
		row_cnt_d  = row_cnt_q;
		bld_len_d  = bld_len_q;
		bld_ovf_d  = bld_ovf_q;
		chk_vld_d  = chk_vld_s1;
		key_d      = key_q;
		lvl_d      = lvl_q;
		chk_lvl_d  = chk_lvl_s1;
		sel_lvl_d  = sel_lvl_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		mid_d      = mid_q;
		res_d      = res_q;
		cmd        = '0;
		b_len      = bld_len_q;
		b_ovf      = bld_ovf_q;
		st         = srss_pkg::ST_ACCEPTED;
		qual       = chk_vld_s1 && (len_rdata != '0) && ($signed(elem_rdata) <= key_q);
		mid        = lo_q + ((hi_q - lo_q) >>> 1);

		unique case (state_q)
			srss_pkg::S_IDLE: begin
				if (in_valid) begin
					res_d.index = '0;
					res_d.level = '0;
					state_d     = srss_pkg::S_RESP;
					unique case (req_type)
						srss_pkg::REQ_LOAD: begin
							// append element, or note the drop
							if (has_value) begin
								if (bld_len_q < LEN_W'(srss_pkg::MAX_ROW_LEN)) begin
									if (row_cnt_q < CNT_W'(srss_pkg::MAX_ROWS)) begin
										cmd.elem_we    = 1'b1;
										cmd.elem_waddr = elem_addr(row_cnt_q[ROW_W-1:0],
											bld_len_q[IDX_W-1:0]);
										cmd.elem_wdata = elem_value;
									end
									b_len = bld_len_q + LEN_W'(1);
								end else begin
									b_ovf = 1'b1;
									st    = srss_pkg::ST_OVERFLOW;
								end
							end
							// push the row, or discard it on a full stack
							if (row_last || !has_value) begin
								if (row_cnt_q < CNT_W'(srss_pkg::MAX_ROWS)) begin
									cmd.len_we    = 1'b1;
									cmd.len_waddr = row_cnt_q[ROW_W-1:0];
									cmd.len_wdata = b_len;
									row_cnt_d     = row_cnt_q + CNT_W'(1);
									if (b_ovf) begin
										st = srss_pkg::ST_OVERFLOW;
									end
								end else begin
									st = srss_pkg::ST_OVERFLOW;
								end
								b_len = '0;
								b_ovf = 1'b0;
							end
							bld_len_d = b_len;
							bld_ovf_d = b_ovf;
						end
						srss_pkg::REQ_POP: begin
							if (row_cnt_q == '0) begin
								st = srss_pkg::ST_UNDERFLOW;
							end else begin
								row_cnt_d = row_cnt_q - CNT_W'(1);
							end
						end
						srss_pkg::REQ_SEARCH: begin
							key_d     = search_key;
							lvl_d     = row_cnt_q;
							chk_vld_d = 1'b0;
							state_d   = srss_pkg::S_SCAN;
						end
						default: begin
						end
					endcase
					res_d.status = st;
					res_d.depth  = row_cnt_d;
				end
			end

			// one row head read per cycle, checked in the cycle after its read
			srss_pkg::S_SCAN: begin
				if (qual) begin
					sel_lvl_d = chk_lvl_s1;
					lo_d      = '0;
					hi_d      = $signed({1'b0, len_rdata}) - (LEN_W+1)'(1);
					chk_vld_d = 1'b0;
					state_d   = srss_pkg::S_BS_RD;
				end else if (lvl_q == '0) begin
					res_d.status = srss_pkg::ST_NOT_FOUND;
					res_d.index  = '0;
					res_d.level  = '0;
					res_d.depth  = row_cnt_q;
					chk_vld_d    = 1'b0;
					state_d      = srss_pkg::S_RESP;
				end else begin
					lvl_d          = lvl_q - CNT_W'(1);
					chk_lvl_d      = ROW_W'(lvl_q - CNT_W'(1));
					chk_vld_d      = 1'b1;
					cmd.len_raddr  = ROW_W'(lvl_q - CNT_W'(1));
					cmd.elem_raddr = elem_addr(ROW_W'(lvl_q - CNT_W'(1)), '0);
				end
			end

			// binary search: issue the probe at mid, or report a miss once the range is empty
			srss_pkg::S_BS_RD: begin
				if (lo_q > hi_q) begin
					res_d.status = srss_pkg::ST_NOT_FOUND;
					res_d.index  = '0;
					res_d.level  = '0;
					res_d.depth  = row_cnt_q;
					state_d      = srss_pkg::S_RESP;
				end else begin
					mid_d          = mid[IDX_W-1:0];
					cmd.elem_raddr = elem_addr(sel_lvl_q, mid[IDX_W-1:0]);
					state_d        = srss_pkg::S_BS_CMP;
				end
			end

			// binary search: compare the probe, report a hit or narrow the range
			srss_pkg::S_BS_CMP: begin
				if ($signed(elem_rdata) == key_q) begin
					res_d.status = srss_pkg::ST_FOUND;
					res_d.index  = mid_q;
					res_d.level  = sel_lvl_q;
					res_d.depth  = row_cnt_q;
					state_d      = srss_pkg::S_RESP;
				end else if ($signed(elem_rdata) < key_q) begin
					lo_d    = $signed({1'b0, LEN_W'(mid_q)}) + (LEN_W+1)'(1);
					state_d = srss_pkg::S_BS_RD;
				end else begin
					hi_d    = $signed({1'b0, LEN_W'(mid_q)}) - (LEN_W+1)'(1);
					state_d = srss_pkg::S_BS_RD;
				end
			end

			srss_pkg::S_RESP: begin
				if (res_ready) begin
					state_d = srss_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = srss_pkg::S_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != srss_pkg::S_IDLE);
	assign res_valid = (state_q == srss_pkg::S_RESP);
	assign res       = res_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= srss_pkg::S_IDLE;
			row_cnt_q  <= '0;
			bld_len_q  <= '0;
			bld_ovf_q  <= 1'b0;
			chk_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			row_cnt_q  <= row_cnt_d;
			bld_len_q  <= bld_len_d;
			bld_ovf_q  <= bld_ovf_d;
			chk_vld_s1 <= chk_vld_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		key_q      <= key_d;
		lvl_q      <= lvl_d;
		chk_lvl_s1 <= chk_lvl_d;
		sel_lvl_q  <= sel_lvl_d;
		lo_q       <= lo_d;
		hi_q       <= hi_d;
		mid_q      <= mid_d;
		res_q      <= res_d;
	end

endmodule

// ----- rtl/srss_checker.sv -----
// ----------------------------------------------------------------------------
// srss_checker
// Port-level checks of the sorted row stack search, bound to the top level.
// ----------------------------------------------------------------------------
module srss_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [2:0]         status,
	input  logic [5:0]         found_index,
	input  logic [3:0]         found_level,
	input  logic [4:0]         stack_depth
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
			$stable(found_index) && $stable(found_level) && $stable(stack_depth))
		else $error("stalled result word changed");

	// one word in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word accepted while one is in work");

	// a hit lies in a row that is on the stack
	a_hit_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == 3'(srss_pkg::ST_FOUND)) |->
			(5'(found_level) < stack_depth))
		else $error("hit reported above the top of the stack");

	// on words other than a hit, position fields are zero and counts stay in range
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != 3'(srss_pkg::ST_FOUND)) |->
			(found_index == '0) && (found_level == '0) &&
			(stack_depth <= 5'(srss_pkg::MAX_ROWS)) &&
			(status <= 3'(srss_pkg::ST_OVERFLOW)))
		else $error("result fields out of range");

endmodule

bind sorted_row_stack_search srss_checker u_srss_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_row_stack_search. A directed table covers
// the empty stack, the value extremes, pops during a build and an unsorted
// row. Random row builds, searches, pops and full-stack bursts follow. Every
// word is scored against the table's result where given, else a behavioral
// copy of the row stack. Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
	localparam int RANDOM_WORDS = 650;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct {
		logic [1:0]         req;
		logic signed [31:0] elem;
		logic               hv;
		logic               last;
		logic signed [31:0] key;
		bit                 typed;
		srss_pkg::res_t     want;
	} dir_word_t;

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic [1:0]         req_type   = srss_pkg::REQ_LOAD;
	logic signed [31:0] elem_value = '0;
	logic               has_value  = 1'b0;
	logic               row_last   = 1'b0;
	logic signed [31:0] search_key = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic [2:0]         status;
	logic [5:0]         found_index;
	logic [3:0]         found_level;
	logic [4:0]         stack_depth;

	// row stack image kept by the bench
	logic signed [31:0] elem_mem [srss_pkg::MAX_ROWS*srss_pkg::MAX_ROW_LEN];
	bit                 elem_set [srss_pkg::MAX_ROWS*srss_pkg::MAX_ROW_LEN];
	int                 level_len [srss_pkg::MAX_ROWS];
	int                 rows_held = 0;
	int                 build_len = 0;
	bit                 build_ovf = 1'b0;

	srss_pkg::res_t results_due [$];
	srss_pkg::res_t head_res;
	dir_word_t      dir_tab [$];
	int             words_sent  = 0;
	int             mismatches  = 0;
	int             cycle_count = 0;
	bit             steady      = 1'b0;

	sorted_row_stack_search i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.elem_value  (elem_value),
		.has_value   (has_value),
		.row_last    (row_last),
		.search_key  (search_key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.found_index (found_index),
		.found_level (found_level),
		.stack_depth (stack_depth)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int pick_wait();
		return steady ? 0 : int'($urandom_range(0, 19));
	endfunction

	// Walk down from the top row, binary-search the first qualifying one.
	// Returns 0 if any element read was never written.
	function automatic bit search_stack(input logic signed [31:0] key,
			output int hit_idx, output int hit_lvl);
		int lvl, lo, hi, mid, base;
		bit clean;
		clean   = 1'b1;
		hit_idx = -1;
		hit_lvl = 0;
		for (lvl = rows_held - 1; lvl >= 0; lvl--) begin
			if (level_len[lvl] == 0)
				continue;
			base  = lvl * srss_pkg::MAX_ROW_LEN;
			clean &= elem_set[base];
			if (!clean || elem_mem[base] > key)
				continue;
			lo = 0;
			hi = level_len[lvl] - 1;
			while (lo <= hi) begin
				mid   = lo + (hi - lo) / 2;
				clean &= elem_set[base + mid];
				if (!clean)
					break;
				if (elem_mem[base + mid] == key) begin
					hit_idx = mid;
					hit_lvl = lvl;
					break;
				end
				if (elem_mem[base + mid] < key)
					lo = mid + 1;
				else
					hi = mid - 1;
			end
			break;
		end
		return clean;
	endfunction

	// Advance the row stack image by one word and return its result
	function automatic srss_pkg::res_t apply_request(input logic [1:0] req,
			input logic signed [31:0] elem, input logic hv, input logic last,
			input logic signed [31:0] key);
		srss_pkg::res_t r;
		int             idx, lvl;
		r        = '0;
		r.status = srss_pkg::ST_ACCEPTED;
		case (req)
			srss_pkg::REQ_LOAD: begin
				if (hv) begin
					if (build_len < srss_pkg::MAX_ROW_LEN) begin
						if (rows_held < srss_pkg::MAX_ROWS) begin
							elem_mem[rows_held*srss_pkg::MAX_ROW_LEN + build_len] = elem;
							elem_set[rows_held*srss_pkg::MAX_ROW_LEN + build_len] = 1'b1;
						end
						build_len++;
					end else begin
						build_ovf = 1'b1;
						r.status  = srss_pkg::ST_OVERFLOW;
					end
				end
				// push, or drop on a full stack
				if (last || !hv) begin
					if (rows_held < srss_pkg::MAX_ROWS) begin
						level_len[rows_held] = build_len;
						rows_held++;
						if (build_ovf)
							r.status = srss_pkg::ST_OVERFLOW;
					end else begin
						r.status = srss_pkg::ST_OVERFLOW;
					end
					build_len = 0;
					build_ovf = 1'b0;
				end
			end
			srss_pkg::REQ_POP: begin
				if (rows_held == 0)
					r.status = srss_pkg::ST_UNDERFLOW;
				else
					rows_held--;
			end
			srss_pkg::REQ_SEARCH: begin
				r.status = srss_pkg::ST_NOT_FOUND;
				void'(search_stack(key, idx, lvl));
				if (idx >= 0) begin
					r.status = srss_pkg::ST_FOUND;
					r.index  = idx[srss_pkg::IDX_W-1:0];
					r.level  = lvl[srss_pkg::ROW_W-1:0];
				end
			end
			default: ;
		endcase
		r.depth = rows_held[srss_pkg::CNT_W-1:0];
		return r;
	endfunction

	// Drive one word after a random gap and hold it until taken
	task automatic send_word(input logic [1:0] req, input logic signed [31:0] elem,
			input logic hv, input logic last, input logic signed [31:0] key,
			input bit typed = 1'b0, input srss_pkg::res_t want = '0);
		srss_pkg::res_t got;
		int             gap;
		gap = pick_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		got = apply_request(req, elem, hv, last, key);
		results_due.push_back(typed ? want : got);
		in_valid   <= 1'b1;
		req_type   <= req;
		elem_value <= elem;
		has_value  <= hv;
		row_last   <= last;
		search_key <= key;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic dir_row(input logic [1:0] req, input logic signed [31:0] elem,
			input logic hv, input logic last, input logic signed [31:0] key,
			input bit typed, input srss_pkg::status_t st, input int idx, input int lvl,
			input int dep);
		dir_word_t w;
		w.req          = req;
		w.elem         = elem;
		w.hv           = hv;
		w.last         = last;
		w.key          = key;
		w.typed        = typed;
		w.want         = '0;
		w.want.status  = st;
		w.want.index   = idx[srss_pkg::IDX_W-1:0];
		w.want.level   = lvl[srss_pkg::ROW_W-1:0];
		w.want.depth   = dep[srss_pkg::CNT_W-1:0];
		dir_tab.push_back(w);
	endtask

	// Key mostly taken from a held row, else extremes or noise
	function automatic logic signed [31:0] pick_key();
		int lvl, k, sel;
		sel = $urandom_range(0, 9);
		if (sel < 6 && rows_held > 0) begin
			lvl = $urandom_range(0, rows_held - 1);
			if (level_len[lvl] > 0) begin
				k = lvl*srss_pkg::MAX_ROW_LEN + int'($urandom_range(0, level_len[lvl] - 1));
				if (elem_set[k])
					return (sel == 5) ? elem_mem[k] + 1 : elem_mem[k];
			end
		end
		if (sel == 6)
			return INT_MIN;
		if (sel == 7)
			return INT_MAX;
		if (sel == 8)
			return int'($urandom_range(0, 80)) - 40;
		return $urandom();
	endfunction

	// Searches that would touch never-written entries are not sent
	task automatic send_search();
		logic signed [31:0] key;
		int idx, lvl;
		key = pick_key();
		if (search_stack(key, idx, lvl))
			send_word(srss_pkg::REQ_SEARCH, $urandom(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), key);
	endtask

	task automatic send_pops(input int n);
		repeat (n)
			send_word(srss_pkg::REQ_POP, $urandom(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), $urandom());
	endtask

	// One row: ascending (saturating) or small unsorted values, closed either
	// by the last flag or by a word without value
	task automatic send_row(input int n, input bit ascending);
		longint             v, step;
		int                 ext, i;
		bit                 close_empty;
		logic signed [31:0] e;
		close_empty = (n == 0) || ($urandom_range(0, 3) == 0);
		ext = $urandom_range(0, 5);
		if (ext < 2)
			v = longint'($urandom_range(0, 80)) - 40;
		else if (ext == 2)
			v = longint'(INT_MIN);
		else
			v = longint'($signed($urandom()));
		for (i = 0; i < n; i++) begin
			// other requests in the middle of a build
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 2) == 0)
					send_pops(1);
				else
					send_search();
			end
			e = ascending ? v[31:0] : int'($urandom_range(0, 20)) - 10;
			send_word(srss_pkg::REQ_LOAD, e, 1'b1, (i == n - 1) && !close_empty,
				$urandom());
			if (ext < 2)
				step = $urandom_range(0, 3);
			else if ($urandom_range(0, 7) == 0)
				step = longint'($urandom());
			else
				step = longint'($urandom_range(1, 1 << 24));
			v += step;
			if (v > longint'(INT_MAX))
				v = longint'(INT_MAX);
		end
		if (close_empty)
			send_word(srss_pkg::REQ_LOAD, $urandom(), 1'b0, 1'($urandom_range(0, 1)),
				$urandom());
	endtask

	task automatic cmp_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, fname, want, got);
			mismatches++;
		end
	endtask

	// score each result word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected word, status %0d index %0d level %0d depth %0d",
					$time, status, found_index, found_level, stack_depth);
				mismatches++;
			end else begin
				head_res = results_due.pop_front();
				cmp_field("status", 32'(head_res.status), 32'(status));
				cmp_field("found_index", 32'(head_res.index), 32'(found_index));
				cmp_field("found_level", 32'(head_res.level), 32'(found_level));
				cmp_field("stack_depth", 32'(head_res.depth), 32'(stack_depth));
			end
		end
	end

	// receiver: random stall before each word
	initial begin
		int n;
		forever begin
			n = pick_wait();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL sorted_row_stack_search");
		$finish;
	end

	initial begin
		int pick;
		// empty stack, unknown request, empty row
		dir_row(srss_pkg::REQ_SEARCH, 0, 1'b0, 1'b0, 0, 1'b1,
			srss_pkg::ST_NOT_FOUND, 0, 0, 0);
		dir_row(srss_pkg::REQ_POP, 0, 1'b0, 1'b0, 0, 1'b1,
			srss_pkg::ST_UNDERFLOW, 0, 0, 0);
		dir_row(REQ_UNKNOWN, INT_MAX, 1'b1, 1'b1, INT_MIN, 1'b1,
			srss_pkg::ST_ACCEPTED, 0, 0, 0);
		dir_row(srss_pkg::REQ_LOAD, 0, 1'b0, 1'b0, 0, 1'b1,
			srss_pkg::ST_ACCEPTED, 0, 0, 1);
		dir_row(srss_pkg::REQ_SEARCH, -1, 1'b1, 1'b1, 5, 1'b1,
			srss_pkg::ST_NOT_FOUND, 0, 0, 1);
		// row of extremes, searched mid-build and after the push
		dir_row(srss_pkg::REQ_LOAD, INT_MIN, 1'b1, 1'b0, 0, 1'b1,
			srss_pkg::ST_ACCEPTED, 0, 0, 1);
		dir_row(srss_pkg::REQ_SEARCH, 0, 1'b0, 1'b0, INT_MIN, 1'b1,
			srss_pkg::ST_NOT_FOUND, 0, 0, 1);
		dir_row(srss_pkg::REQ_LOAD, -5, 1'b1, 1'b0, -1, 1'b0,
			srss_pkg::ST_ACCEPTED, 0, 0, 0);
		dir_row(srss_pkg::REQ_LOAD, 0, 1'b1, 1'b0, -1, 1'b0,
			srss_pkg::ST_ACCEPTED, 0, 0, 0);
		dir_row(srss_pkg::REQ_LOAD, 7, 1'b1, 1'b0, -1, 1'b0,
			srss_pkg::ST_ACCEPTED, 0, 0, 0);
		dir_row(srss_pkg::REQ_LOAD, INT_MAX, 1'b1, 1'b1, 0, 1'b1,
			srss_pkg::ST_ACCEPTED, 0, 0, 2);
		dir_row(srss_pkg::REQ_SEARCH, 0, 1'b0, 1'b0, INT_MIN, 1'b1,
			srss_pkg::ST_FOUND, 0, 1, 2);
		dir_row(srss_pkg::REQ_SEARCH, 0, 1'b0, 1'b0, INT_MAX, 1'b1,
			srss_pkg::ST_FOUND, 4, 1, 2);
		dir_row(srss_pkg::REQ_SEARCH, 0, 1'b0, 1'b0, 1, 1'b0,
			srss_pkg::ST_ACCEPTED, 0, 0, 0);
		// pop in the middle of a build
		dir_row(srss_pkg::REQ_LOAD, 3, 1'b1, 1'b0, 0, 1'b0,
			srss_pkg::ST_ACCEPTED, 0, 0, 0);
		dir_row(srss_pkg::REQ_POP, 0, 1'b1, 1'b0, 0, 1'b0,
			srss_pkg::ST_ACCEPTED, 0, 0, 0);
		dir_row(srss_pkg::REQ_LOAD, 4, 1'b1, 1'b1, 0, 1'b0,
			srss_pkg::ST_ACCEPTED, 0, 0, 0);
		dir_row(srss_pkg::REQ_SEARCH, 0, 1'b0, 1'b0, 4, 1'b0,
			srss_pkg::ST_ACCEPTED, 0, 0, 0);
		// unsorted row misses a present key; lower rows not tried
		dir_row(srss_pkg::REQ_LOAD, 5, 1'b1, 1'b0, 0, 1'b0,
			srss_pkg::ST_ACCEPTED, 0, 0, 0);
		dir_row(srss_pkg::REQ_LOAD, 20, 1'b1, 1'b0, 0, 1'b0,
			srss_pkg::ST_ACCEPTED, 0, 0, 0);
		dir_row(srss_pkg::REQ_LOAD, 10, 1'b1, 1'b1, 0, 1'b0,
			srss_pkg::ST_ACCEPTED, 0, 0, 0);
		dir_row(srss_pkg::REQ_SEARCH, 0, 1'b0, 1'b0, 10, 1'b0,
			srss_pkg::ST_ACCEPTED, 0, 0, 0);
		dir_row(srss_pkg::REQ_SEARCH, 0, 1'b0, 1'b0, 4, 1'b0,
			srss_pkg::ST_ACCEPTED, 0, 0, 0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_word(dir_tab[i].req, dir_tab[i].elem, dir_tab[i].hv, dir_tab[i].last,
				dir_tab[i].key, dir_tab[i].typed, dir_tab[i].want);

		// random phase
		while (words_sent < dir_tab.size() + RANDOM_WORDS) begin
			if ($urandom_range(0, 9) == 0)
				steady = !steady;
			pick = $urandom_range(0, 99);
			if (pick < 42) begin
				if ($urandom_range(0, 14) == 0)
					send_row($urandom_range(srss_pkg::MAX_ROW_LEN - 3,
						srss_pkg::MAX_ROW_LEN + 6), 1'b1);
				else
					send_row($urandom_range(0, 8), 1'b1);
			end else if (pick < 70) begin
				send_search();
			end else if (pick < 82) begin
				send_pops(rows_held > 10 ? $urandom_range(1, 6) : $urandom_range(1, 2));
			end else if (pick < 87) begin
				send_word(REQ_UNKNOWN, $urandom(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), $urandom());
			end else if (pick < 94) begin
				send_row($urandom_range(1, 8), 1'b0);
			end else begin
				// fill the stack, then push rows that get dropped
				while (rows_held < srss_pkg::MAX_ROWS)
					send_row($urandom_range(0, 3), 1'b1);
				repeat ($urandom_range(1, 2))
					send_row($urandom_range(0, 4), 1'b1);
			end
		end
		in_valid <= 1'b0;

		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS sorted_row_stack_search");
		else
			$display("FAIL sorted_row_stack_search");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/srss_pkg.sv
rtl/srss_store.sv
rtl/srss_ctrl.sv
rtl/sorted_row_stack_search.sv
rtl/srss_checker.sv
dv/tb_top.sv
